@@ rtl/core/pte_pkg.sv @@
// Package with the shared types, constants and control store of the entry selector.
`timescale 1ns / 1ps
`default_nettype none

package pte_pkg;

    // Field widths of one item.
    localparam int ID_W   = 6;
    localparam int PRIO_W = 4;
    localparam int KEY_W  = 32;

    // Key value that never wins the ascending modes.
    localparam logic [KEY_W-1:0] KEY_ALL_ONES = {KEY_W{1'b1}};

    // Command codes.
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_DECIDE = 1'b1;

    // Selection modes; the remaining code selects nothing.
    localparam logic [1:0] MODE_OLDEST   = 2'd0;
    localparam logic [1:0] MODE_NEWEST   = 2'd1;
    localparam logic [1:0] MODE_SMALLEST = 2'd2;

    // One stored table entry.
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [KEY_W-1:0]  timestamp;
        logic [KEY_W-1:0]  size;
    } entry_t;

    // Program steps of the sequencer, one-hot.
    typedef enum logic [5:0] {
        STEP_CLEAR = 6'b000001,
        STEP_IDLE  = 6'b000010,
        STEP_SETUP = 6'b000100,
        STEP_SCAN  = 6'b001000,
        STEP_DRAIN = 6'b010000,
        STEP_EMIT  = 6'b100000
    } step_t;

    // Jump conditions.
    typedef enum logic [1:0] {
        COND_NEVER    = 2'd0,
        COND_CNT_MORE = 2'd1,
        COND_DECIDE   = 2'd2,
        COND_OUT_BUSY = 2'd3
    } cond_t;

    // One control word.
    typedef struct packed {
        logic  clr_wr;
        logic  accept_en;
        logic  scan_init;
        logic  rd_en;
        logic  cmp_en;
        logic  emit;
        cond_t cond;
        step_t jump_to;
        step_t next_to;
    } ctrl_t;

    // Control store: the control word for each step.
    function automatic ctrl_t ucode(step_t s);
        ctrl_t w;
        w = '0;
        w.cond    = COND_NEVER;
        w.jump_to = STEP_IDLE;
        w.next_to = STEP_IDLE;
        unique case (s)
            STEP_CLEAR:
            begin
                w.clr_wr  = 1'b1;
                w.cond    = COND_CNT_MORE;
                w.jump_to = STEP_CLEAR;
                w.next_to = STEP_IDLE;
            end
            STEP_IDLE:
            begin
                w.accept_en = 1'b1;
                w.cond      = COND_DECIDE;
                w.jump_to   = STEP_SETUP;
                w.next_to   = STEP_IDLE;
            end
            STEP_SETUP:
            begin
                w.scan_init = 1'b1;
                w.next_to   = STEP_SCAN;
            end
            STEP_SCAN:
            begin
                w.rd_en   = 1'b1;
                w.cmp_en  = 1'b1;
                w.cond    = COND_CNT_MORE;
                w.jump_to = STEP_SCAN;
                w.next_to = STEP_DRAIN;
            end
            STEP_DRAIN:
            begin
                w.cmp_en  = 1'b1;
                w.next_to = STEP_EMIT;
            end
            STEP_EMIT:
            begin
                w.emit    = 1'b1;
                w.cond    = COND_OUT_BUSY;
                w.jump_to = STEP_EMIT;
                w.next_to = STEP_IDLE;
            end
            default:
            begin
                w.next_to = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/pte_req_if.sv @@
// Request channel: commands and entry fields with a valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface pte_req_if;
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [pte_pkg::ID_W-1:0]   entry_id;
    logic [pte_pkg::PRIO_W-1:0] entry_priority;
    logic [pte_pkg::KEY_W-1:0]  entry_timestamp;
    logic [pte_pkg::KEY_W-1:0]  entry_size;

    modport source (
        output valid, command, entry_id, entry_priority, entry_timestamp, entry_size,
        input  ready
    );

    modport sink (
        input  valid, command, entry_id, entry_priority, entry_timestamp, entry_size,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/pte_rsp_if.sv @@
// Response channel: chosen id and found flag with a valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface pte_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [pte_pkg::ID_W-1:0] chosen_id;
    logic                     found;

    modport source (
        output valid, chosen_id, found,
        input  ready
    );

    modport sink (
        input  valid, chosen_id, found,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/pte_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module pte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/priority_tiered_entry_selector.sv @@
// Top level of the priority-tiered entry selector with its microcoded scan sequencer.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req.valid/req.ready   command, entry_id, entry_priority,
//                                             entry_timestamp, entry_size
//   rsp      out        rsp.valid/rsp.ready   chosen_id, found
//   cfg      in         cfg_wr_en             cfg_wr_data (select_mode)
//
// A write item is accepted in the idle step. A decide item runs through accept,
// setup, NUM_ENTRIES - 1 reads of the entry RAM through its single read port into
// one comparator, a drain step and the result load.
// After reset the entry RAM is cleared one entry per cycle, all NUM_ENTRIES entries,
// during which no item is accepted.
// A result waits in an output register; writes are still accepted meanwhile, and
// only the next decide stalls in its load step until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module priority_tiered_entry_selector #(
    parameter int NUM_ENTRIES = 64,
    parameter int NUM_LEVELS  = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_wr_data,
    pte_req_if.sink         req,
    pte_rsp_if.source       rsp
);

    localparam int AW = $clog2(NUM_ENTRIES);
    localparam int CW = $clog2(NUM_ENTRIES + 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(NUM_ENTRIES - 1);
    localparam logic [pte_pkg::PRIO_W-1:0] MAX_LEVEL = pte_pkg::PRIO_W'(NUM_LEVELS);
    localparam int EW = $bits(pte_pkg::entry_t);

    // Sequencer and datapath registers.
    pte_pkg::step_t              step_reg, step_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic [1:0]                  mode_reg, mode_next;
    logic                        rd_pend_reg, rd_pend_next;
    logic [AW-1:0]               rd_id_reg, rd_id_next;
    logic                        best_found_reg, best_found_next;
    logic [pte_pkg::PRIO_W-1:0]  best_lvl_reg, best_lvl_next;
    logic [pte_pkg::KEY_W-1:0]   best_key_reg, best_key_next;
    logic [AW-1:0]               best_id_reg, best_id_next;
    logic                        out_valid_reg, out_valid_next;
    logic [pte_pkg::ID_W-1:0]    out_id_reg, out_id_next;
    logic                        out_found_reg, out_found_next;

    pte_pkg::ctrl_t              ctrl;
    pte_pkg::entry_t             ent;
    pte_pkg::entry_t             wr_ent;
    logic                        req_fire;
    logic                        cnt_more;
    logic                        out_busy;
    logic                        cond_true;
    logic                        id_in_range;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [EW-1:0]               ram_wdata;
    logic [EW-1:0]               ram_rdata;
    logic                        cmp_fire;
    logic [pte_pkg::KEY_W-1:0]   key;
    logic                        newest;
    logic                        mode_ok;
    logic                        lvl_ok;
    logic                        key_ok;
    logic                        key_better;
    logic                        take;

    // Control word of the current step.
    assign ctrl = pte_pkg::ucode(step_reg);

    // Handshakes and status.
    assign req.ready = ctrl.accept_en;
    assign req_fire  = req.valid && req.ready;
    assign cnt_more  = cnt_reg != LAST_CNT;
    assign out_busy  = out_valid_reg && !rsp.ready;

    // Jump condition select.
    always_comb
    begin
        unique case (ctrl.cond)
            pte_pkg::COND_NEVER:    cond_true = 1'b0;
            pte_pkg::COND_CNT_MORE: cond_true = cnt_more;
            pte_pkg::COND_DECIDE:   cond_true = req_fire && (req.command == pte_pkg::CMD_DECIDE);
            pte_pkg::COND_OUT_BUSY: cond_true = out_busy;
        endcase
    end

    assign step_next = cond_true ? ctrl.jump_to : ctrl.next_to;

    // Entry RAM write port: clearing pass or an accepted write item.
    assign id_in_range = 32'(req.entry_id) < 32'(NUM_ENTRIES);
    assign wr_ent.prio      = req.entry_priority;
    assign wr_ent.timestamp = req.entry_timestamp;
    assign wr_ent.size      = req.entry_size;
    assign ram_we    = ctrl.clr_wr
                       || (req_fire && (req.command == pte_pkg::CMD_WRITE) && id_in_range);
    assign ram_waddr = ctrl.clr_wr ? cnt_reg[AW-1:0] : AW'(req.entry_id);
    assign ram_wdata = ctrl.clr_wr ? '0 : EW'(wr_ent);

    pte_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ctrl.rd_en),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Comparator: does the entry just read beat the best one so far?
    always_comb
    begin
        ent        = pte_pkg::entry_t'(ram_rdata);
        cmp_fire   = ctrl.cmp_en && rd_pend_reg;
        newest     = mode_reg == pte_pkg::MODE_NEWEST;
        mode_ok    = (mode_reg == pte_pkg::MODE_OLDEST) || newest
                     || (mode_reg == pte_pkg::MODE_SMALLEST);
        key        = (mode_reg == pte_pkg::MODE_SMALLEST) ? ent.size : ent.timestamp;
        lvl_ok     = (ent.prio != '0) && (ent.prio <= MAX_LEVEL);
        key_ok     = (key != '0) && (newest || (key != pte_pkg::KEY_ALL_ONES));
        key_better = newest ? (key > best_key_reg) : (key < best_key_reg);
        take       = cmp_fire && mode_ok && lvl_ok && key_ok
                     && (!best_found_reg || (ent.prio < best_lvl_reg)
                         || ((ent.prio == best_lvl_reg) && key_better));
    end

    // Next values of counter, best entry and output register.
    always_comb
    begin
        mode_next       = cfg_wr_en ? cfg_wr_data : mode_reg;
        rd_pend_next    = ctrl.rd_en;
        rd_id_next      = ctrl.rd_en ? cnt_reg[AW-1:0] : rd_id_reg;

        cnt_next = cnt_reg;
        if (ctrl.scan_init)
        begin
            cnt_next = CW'(1);
        end
        else if (ctrl.clr_wr || ctrl.rd_en)
        begin
            cnt_next = cnt_reg + CW'(1);
        end

        best_found_next = best_found_reg;
        best_lvl_next   = best_lvl_reg;
        best_key_next   = best_key_reg;
        best_id_next    = best_id_reg;
        if (ctrl.scan_init)
        begin
            best_found_next = 1'b0;
        end
        else if (take)
        begin
            best_found_next = 1'b1;
            best_lvl_next   = ent.prio;
            best_key_next   = key;
            best_id_next    = rd_id_reg;
        end

        out_valid_next = out_valid_reg && !rsp.ready;
        out_id_next    = out_id_reg;
        out_found_next = out_found_reg;
        if (ctrl.emit && !out_busy)
        begin
            out_valid_next = 1'b1;
            out_found_next = best_found_reg;
            out_id_next    = best_found_reg ? pte_pkg::ID_W'(best_id_reg) : '0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= pte_pkg::STEP_CLEAR;
            cnt_reg        <= '0;
            mode_reg       <= pte_pkg::MODE_OLDEST;
            rd_pend_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            step_reg       <= step_next;
            cnt_reg        <= cnt_next;
            mode_reg       <= mode_next;
            rd_pend_reg    <= rd_pend_next;
            best_found_reg <= best_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_id_reg     <= rd_id_next;
        best_lvl_reg  <= best_lvl_next;
        best_key_reg  <= best_key_next;
        best_id_reg   <= best_id_next;
        out_id_reg    <= out_id_next;
        out_found_reg <= out_found_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.chosen_id = out_id_reg;
    assign rsp.found     = out_found_reg;

`ifndef NO_ASSERTIONS
    // A result without a find carries id 0, and a find never carries id 0.
    a_found_id: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.found == (rsp.chosen_id != '0)))
        else $error("found flag and chosen id disagree");

    // A kept best entry always lies on a scanned level.
    a_best_level: assert property (@(posedge clk) disable iff (!rst_n)
        best_found_reg |-> ((best_lvl_reg != '0) && (best_lvl_reg <= MAX_LEVEL)))
        else $error("best entry on a level that is never scanned");

    // The drain step only follows the last scan read.
    a_drain_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == pte_pkg::STEP_DRAIN) |-> ($past(step_reg) == pte_pkg::STEP_SCAN
                                               && $past(cnt_reg) == LAST_CNT))
        else $error("drain step entered before the scan finished");
`endif

endmodule

`default_nettype wire

@@ tb/sv/pte_selection_checker.sv @@
// Checker that predicts each selection of the entry selector and compares the results.
`timescale 1ns / 1ps

module pte_selection_checker #(
    parameter int NUM_ENTRIES = 64,
    parameter int NUM_LEVELS  = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    pte_req_if         req,
    pte_rsp_if         rsp,
    output int         mismatches,
    output int         pending_results
);
    import pte_pkg::*;

    // One expected or observed selection.
    typedef struct packed {
        logic [ID_W-1:0] chosen_id;
        logic            found;
    } selection_t;

    // Shadow copy of the entry table and the mode register.
    logic [PRIO_W-1:0] level_of     [NUM_ENTRIES];
    logic [KEY_W-1:0]  timestamp_of [NUM_ENTRIES];
    logic [KEY_W-1:0]  size_of      [NUM_ENTRIES];
    logic [1:0]        sel_mode;

    // Selections still owed by the block, oldest first.
    selection_t expected_selections[$];

    // Scan the levels from the highest priority down and pick the winner of the first
    // level that holds a usable key. Id 0 never takes part.
    function automatic selection_t predict_selection();
        selection_t       sel;
        logic [ID_W-1:0]  best_id;
        logic [KEY_W-1:0] best_key;
        logic [KEY_W-1:0] key;
        logic             better;
        sel = '0;
        if (sel_mode == MODE_OLDEST || sel_mode == MODE_NEWEST || sel_mode == MODE_SMALLEST)
        begin
            for (int lvl = 1; lvl <= NUM_LEVELS; lvl++)
            begin
                best_id  = '0;
                best_key = (sel_mode == MODE_NEWEST) ? '0 : KEY_ALL_ONES;
                for (int id = 1; id < NUM_ENTRIES; id++)
                begin
                    if (int'(level_of[id]) != lvl)
                        continue;
                    key = (sel_mode == MODE_SMALLEST) ? size_of[id] : timestamp_of[id];
                    if (key == '0)
                        continue;
                    // Strict compare keeps the lowest id on a tie.
                    better = (sel_mode == MODE_NEWEST) ? (key > best_key) : (key < best_key);
                    if (better)
                    begin
                        best_key = key;
                        best_id  = ID_W'(id);
                    end
                end
                if (best_id != '0 && !sel.found)
                begin
                    sel.chosen_id = best_id;
                    sel.found     = 1'b1;
                end
            end
        end
        return sel;
    endfunction

    // Follow register writes and accepted items, and compare each accepted result.
    always @(posedge clk or negedge rst_n)
    begin : track
        selection_t want;
        int         step_errors;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                level_of[i]     = '0;
                timestamp_of[i] = '0;
                size_of[i]      = '0;
            end
            sel_mode = MODE_OLDEST;
            expected_selections.delete();
            mismatches      <= 0;
            pending_results <= 0;
        end
        else
        begin
            step_errors = 0;
            if (cfg_wr_en)
                sel_mode = cfg_wr_data;

            if (req.valid && req.ready)
            begin
                if (req.command == CMD_WRITE)
                begin
                    level_of[req.entry_id]     = req.entry_priority;
                    timestamp_of[req.entry_id] = req.entry_timestamp;
                    size_of[req.entry_id]      = req.entry_size;
                end
                else
                begin
                    expected_selections.push_back(predict_selection());
                end
            end

            if (rsp.valid && rsp.ready)
            begin
                if (expected_selections.size() == 0)
                begin
                    $display("%0t: result with no decide pending: chosen_id %0d found %0d",
                             $time, rsp.chosen_id, rsp.found);
                    step_errors++;
                end
                else
                begin
                    want = expected_selections.pop_front();
                    if (rsp.chosen_id !== want.chosen_id)
                    begin
                        $display("%0t: chosen_id expected %0d, actual %0d",
                                 $time, want.chosen_id, rsp.chosen_id);
                        step_errors++;
                    end
                    if (rsp.found !== want.found)
                    begin
                        $display("%0t: found expected %0d, actual %0d",
                                 $time, want.found, rsp.found);
                        step_errors++;
                    end
                end
            end

            mismatches      <= mismatches + step_errors;
            pending_results <= expected_selections.size();
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
// Top of the entry selector testbench: clock, reset, stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module tb_top;
    import pte_pkg::*;

    localparam int                NUM_ENTRIES      = 64;
    localparam int                NUM_LEVELS       = 8;
    localparam int                SETTLE_CYCLES    = NUM_ENTRIES + 8;
    localparam int                LONG_HOLD_CYCLES = 300;
    localparam int                DECIDE_PCT       = 15;
    localparam logic [1:0]        MODE_UNUSED      = 2'd3;
    localparam logic [PRIO_W-1:0] PRIO_MAX         = '1;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [1:0] cfg_wr_data;
    int         mismatches;
    int         pending_results;
    int         src_idle_pct  = 0;
    int         sink_idle_pct = 0;
    int         hold_requests = 0;

    pte_req_if req_ch();
    pte_rsp_if rsp_ch();

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    priority_tiered_entry_selector #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .NUM_LEVELS  (NUM_LEVELS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    pte_selection_checker #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .NUM_LEVELS  (NUM_LEVELS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    // Offer one item after a random idle gap and hold it until it is accepted.
    task automatic send_item(logic cmd, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
                             logic [KEY_W-1:0] ts, logic [KEY_W-1:0] sz);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.command         <= cmd;
        req_ch.entry_id        <= id;
        req_ch.entry_priority  <= prio;
        req_ch.entry_timestamp <= ts;
        req_ch.entry_size      <= sz;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic write_entry(logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
                               logic [KEY_W-1:0] ts, logic [KEY_W-1:0] sz);
        send_item(CMD_WRITE, id, prio, ts, sz);
    endtask

    // A decide carries random entry fields, which the block must ignore.
    task automatic send_decide();
        send_item(CMD_DECIDE, ID_W'($urandom), PRIO_W'($urandom), $urandom, $urandom);
    endtask

    // Priority mix: crowded top levels, the full legal range, absent entries and
    // levels that are never scanned.
    function automatic logic [PRIO_W-1:0] rand_priority();
        case ($urandom_range(9))
            0, 1:       return PRIO_W'($urandom_range(1, 2));
            2, 3, 4, 5: return PRIO_W'($urandom_range(1, NUM_LEVELS));
            6, 7:       return '0;
            default:    return PRIO_W'($urandom_range(NUM_LEVELS + 1, int'(PRIO_MAX)));
        endcase
    endfunction

    // Key mix: missing keys, all ones and its neighbor, small values that tie often.
    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(9))
            0:       return '0;
            1:       return KEY_ALL_ONES;
            2:       return KEY_ALL_ONES - 1'b1;
            3, 4, 5: return KEY_W'($urandom_range(1, 6));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_write();
        write_entry(ID_W'($urandom_range(0, NUM_ENTRIES - 1)), rand_priority(),
                    rand_key(), rand_key());
    endtask

    task automatic send_random_item();
        if ($urandom_range(99) < DECIDE_PCT)
            send_decide();
        else
            send_random_write();
    endtask

    // Stop offering, wait for every owed result, then let a late scan finish.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Change the selection mode only while the block is idle.
    task automatic apply_select_mode(logic [1:0] mode);
        drain_results();
        cfg_wr_data <= mode;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // One idling setting: a round of random items for each mode.
    task automatic run_random_phase(bit with_pressure);
        logic [1:0] modes [4];
        int         count;
        modes = '{MODE_OLDEST, MODE_SMALLEST, MODE_NEWEST, MODE_UNUSED};
        for (int r = 0; r < 4; r++)
        begin
            apply_select_mode(modes[r]);
            // Long result stall: the output register fills and the next decide blocks.
            if (with_pressure && r == 0)
            begin
                hold_requests++;
                for (int i = 0; i < 16; i++)
                begin
                    if (i % 4 == 0)
                        send_decide();
                    else
                        send_random_write();
                end
            end
            count = (modes[r] == MODE_UNUSED) ? 30 : 60;
            for (int i = 0; i < count; i++)
                send_random_item();
        end
    endtask

    // Result side: random stalls plus an occasional long hold-off on request.
    initial
    begin : sink_side
        int hold_left;
        int holds_seen;
        hold_left    = 0;
        holds_seen   = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                hold_left  = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_wr_data            = MODE_OLDEST;
        req_ch.valid           = 1'b0;
        req_ch.command         = CMD_WRITE;
        req_ch.entry_id        = '0;
        req_ch.entry_priority  = '0;
        req_ch.entry_timestamp = '0;
        req_ch.entry_size      = '0;
        src_idle_pct           = 31;
        sink_idle_pct          = 88;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed checks in the reset mode: empty table, id 0, all-ones key,
        // a level beyond the scan, an empty top level and a tie.
        send_decide();
        write_entry(6'd0, 4'd1, 32'd5, 32'd5);
        send_decide();
        write_entry(6'd63, PRIO_W'(NUM_LEVELS), KEY_ALL_ONES, 32'd7);
        write_entry(6'd5, PRIO_MAX, 32'd3, 32'd3);
        send_decide();
        write_entry(6'd10, 4'd2, 32'd100, 32'd0);
        write_entry(6'd11, 4'd2, 32'd100, 32'd9);
        write_entry(6'd12, 4'd1, 32'd0, KEY_ALL_ONES);
        write_entry(6'd1, 4'd3, KEY_ALL_ONES - 1'b1, 32'd1);
        send_decide();

        // Newest mode, where an all-ones timestamp may win.
        apply_select_mode(MODE_NEWEST);
        send_decide();
        write_entry(6'd20, 4'd2, KEY_ALL_ONES, 32'd0);
        send_decide();

        // Smallest size, then the code that selects nothing.
        apply_select_mode(MODE_SMALLEST);
        send_decide();
        apply_select_mode(MODE_UNUSED);
        send_decide();

        // Random traffic under three idling settings.
        run_random_phase(1'b0);
        src_idle_pct  = 88;
        sink_idle_pct = 31;
        run_random_phase(1'b0);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random_phase(1'b1);

        drain_results();
        if (mismatches == 0)
            $display("priority_tiered_entry_selector verification clean");
        else
            $display("priority_tiered_entry_selector verification failed");
        $finish;
    end

    // Watchdog for a hung handshake or a result that never comes.
    initial
    begin
        #5_000_000;
        $display("priority_tiered_entry_selector verification failed");
        $finish;
    end

endmodule
